// ===== design/b64e_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef enum logic [1:0] {
		PAD_NONE = 2'd0,
		PAD_ONE  = 2'd1,
		PAD_TWO  = 2'd2
	} pad_t;

	typedef struct packed {
		logic [23:0] word;
		pad_t        pad;
		logic        last;
	} group_t;

	typedef struct packed {
		logic   valid;
		group_t grp;
	} queue_out_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] c;
		c = 8'h2F;
		if (v < 6'd26) begin
			c = 8'(8'h41 + {2'b00, v});
		end else if (v < 6'd52) begin
			c = 8'(8'h61 + {2'b00, v} - 8'd26);
		end else if (v < 6'd62) begin
			c = 8'(8'h30 + {2'b00, v} - 8'd52);
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/b64e_front.sv =====
// Front end: accepts raw bytes, gathers them into groups of three and
// classifies each finished group by its padding. Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      in_byte,
	input  wire logic            in_last,
	input  wire logic            q_full,
	output logic                 push,
	output b64e_pkg::group_t     push_grp
);

	logic [15:0] pend_q;
	logic [1:0]  pos_q;
	logic        xfer;

	assign in_ready = !q_full;
	assign xfer     = in_valid && in_ready;

	always_comb begin
		push          = 1'b0;
		push_grp.word = {pend_q, in_byte};
		push_grp.pad  = b64e_pkg::PAD_NONE;
		push_grp.last = in_last;
		unique case (pos_q)
			2'd1: begin
				push          = xfer && in_last;
				push_grp.word = {pend_q[15:8], in_byte, 8'h00};
				push_grp.pad  = b64e_pkg::PAD_ONE;
			end
			2'd2: begin
				push = xfer;
			end
			default: begin
				push          = xfer && in_last;
				push_grp.word = {in_byte, 16'h0000};
				push_grp.pad  = b64e_pkg::PAD_TWO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pos_q  <= '0;
		end else if (xfer) begin
			unique case (pos_q)
				2'd1: begin
					pend_q[7:0] <= in_byte;
					pos_q       <= in_last ? 2'd0 : 2'd2;
				end
				2'd2: begin
					pos_q <= 2'd0;
				end
				default: begin
					pend_q <= {in_byte, 8'h00};
					pos_q  <= in_last ? 2'd0 : 2'd1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/b64e_queue.sv =====
// Short group queue between front and back ends, built from flops.
// Depends on b64e_pkg for the group record.
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue #(
	parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire b64e_pkg::group_t    push_grp,
	output logic                     full,
	input  wire logic                pop,
	output b64e_pkg::queue_out_t     head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	b64e_pkg::group_t mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_pop;

	assign full       = cnt_q == CW'(DEPTH);
	assign head.valid = cnt_q != '0;
	assign head.grp   = mem_q[rd_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
			end
			if (push && !do_pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (!push && do_pop) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/b64e_back.sv =====
// Back end: serializes each group into four characters, one per cycle while
// out_ready is high, through a registered output stage. Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire b64e_pkg::queue_out_t head,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [7:0]               out_char,
	output logic                     out_last
);

	b64e_pkg::group_t grp_q;
	logic [1:0]       idx_q;
	logic             busy_q;
	logic             valid_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic             advance;
	logic [5:0]       sextet;
	logic             is_pad;
	logic [7:0]       next_char;

	assign advance = busy_q && (!valid_q || out_ready);
	assign pop     = head.valid && (!busy_q || (advance && idx_q == 2'd3));

	always_comb begin
		unique case (idx_q)
			2'd0:    sextet = grp_q.word[23:18];
			2'd1:    sextet = grp_q.word[17:12];
			2'd2:    sextet = grp_q.word[11:6];
			default: sextet = grp_q.word[5:0];
		endcase
		is_pad = ((idx_q == 2'd2) && (grp_q.pad == b64e_pkg::PAD_TWO)) ||
			((idx_q == 2'd3) && (grp_q.pad != b64e_pkg::PAD_NONE));
		next_char = is_pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_char(sextet);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			char_q <= next_char;
			last_q <= grp_q.last && (idx_q == 2'd3);
		end
		if (pop) begin
			grp_q <= head.grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				idx_q  <= '0;
				busy_q <= 1'b1;
			end else if (advance) begin
				idx_q <= 2'(idx_q + 1'b1);
				if (idx_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

// ===== design/base64_stream_encoder_core.sv =====
// Streaming base64 encoder (standard alphabet, padded output).
// Input channel s_*: one raw byte per transfer, s_tlast on the final byte
// of a message. Output channel m_*: one ASCII character per transfer,
// m_tlast on the final character of the encoded message.
// A byte that does not finish a group and is not last yields nothing; a
// third byte, or a last byte, yields four characters ('=' pads for a short
// final group). With the back end idle, the byte that finishes a group
// passes the group queue, the back end's group register and its output
// register on its way to m_*; the four characters follow on consecutive
// cycles while m_tready is high. The back end emits one character per cycle
// while m_tready is high, four characters for every three input bytes;
// s_tready stays high while the group queue between front and back ends has
// room. Under sustained input the queue fills even with m_tready high, and
// s_tready then drops.
// When m_tready is low the character holds on m_tdata and the queue fills;
// then s_tready drops. arst_n clears the byte group, the queue and the
// output stage; the block accepts bytes on the first cycle after reset.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder_core #(
	parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tlast,   // last_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_char
	output logic            m_tlast    // last_char
);

	logic                 push;
	b64e_pkg::group_t     push_grp;
	logic                 q_full;
	logic                 pop;
	b64e_pkg::queue_out_t head;

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.push_grp (push_grp)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.full     (q_full),
		.pop      (pop),
		.head     (head)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

`default_nettype wire
